/* sv/jeu_pkg.sv */
// Shared types and constants for the response envelope checker.
`default_nettype none

package jeu_pkg;

  // Message length counter saturates at 2^24.
  localparam int unsigned LEN_W = 25;
  localparam int unsigned MAX_LEN_W = 24;
  localparam logic [LEN_W-1:0] COUNT_CAP = 25'h100_0000;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 24'd65536;

  // Key text "abiVersion":1 with its quotes, first byte at index 0.
  localparam int unsigned KEY_LEN = 14;
  localparam int unsigned WIN_LEN = KEY_LEN - 1;
  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h22, 8'h61, 8'h62, 8'h69, 8'h56, 8'h65, 8'h72,
    8'h73, 8'h69, 8'h6f, 8'h6e, 8'h22, 8'h3a, 8'h31
  };

  // Envelope delimiters.
  localparam logic [7:0] OPEN_BRACE = 8'h7b;
  localparam logic [7:0] CLOSE_BRACE = 8'h7d;

  // UTF-8 byte classes.
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_CODE = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_CODE = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_CODE = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_CODE = 8'hf0;

  // Code point limits.
  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007f;
  localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007ff;
  localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00ffff;
  localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00d800;
  localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00dfff;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10ffff;

  // Continuation counts of a multibyte sequence.
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_VALID     = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_TOO_LARGE = 2'd2
  } verdict_t;

  // Text decoder status after the current byte.
  typedef struct packed {
    logic text_error;
    logic seq_open;
  } utf8_status_t;

endpackage

`default_nettype wire

/* sv/jeu_if.sv */
// Valid/ready channel interfaces for input bytes and verdict items.
`default_nettype none

interface jeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jeu_out_if;
  logic              valid;
  logic              ready;
  jeu_pkg::verdict_t verdict;
  logic [24:0]       message_length;

  modport source (output valid, output verdict, output message_length, input ready);
  modport sink (input valid, input verdict, input message_length, output ready);
endinterface

`default_nettype wire

/* sv/jeu_utf8_tracker.sv */
// Strict UTF-8 decoder state with sticky error, one byte per step.
`default_nettype none

module jeu_utf8_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  flush,
  input  wire logic [7:0]            data_byte,
  output jeu_pkg::utf8_status_t      status
);
  import jeu_pkg::*;

  logic [1:0]      pend_r, pend_nxt;
  logic [1:0]      seq_r, seq_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            err_r, err_nxt;
  logic [CP_W-1:0] cp_sh;
  logic            bad_cp;

  // Decode one byte against the current sequence state.
  always_comb begin
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    cp_nxt   = cp_r;
    err_nxt  = err_r;
    cp_sh    = {cp_r[CP_W-7:0], data_byte[5:0]};
    bad_cp   = (cp_sh <= CP_MAX_1B) ||
               ((cp_sh <= CP_MAX_2B) && (seq_r == SEQ_THREE)) ||
               ((cp_sh <= CP_MAX_3B) && (seq_r == SEQ_FOUR)) ||
               ((cp_sh >= CP_SURR_LO) && (cp_sh <= CP_SURR_HI)) ||
               (cp_sh > CP_MAX);
    if (pend_r == SEQ_NONE) begin
      if (!data_byte[7]) begin
        if (data_byte < CTRL_LIMIT) begin
          err_nxt = 1'b1;
        end
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
        cp_nxt   = {16'd0, data_byte[4:0]};
        pend_nxt = SEQ_TWO;
        seq_nxt  = SEQ_TWO;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
        cp_nxt   = {17'd0, data_byte[3:0]};
        pend_nxt = SEQ_THREE;
        seq_nxt  = SEQ_THREE;
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
        cp_nxt   = {18'd0, data_byte[2:0]};
        pend_nxt = SEQ_FOUR;
        seq_nxt  = SEQ_FOUR;
      end else begin
        err_nxt = 1'b1;
      end
    end else begin
      if ((data_byte & CONT_MASK) != CONT_CODE) begin
        err_nxt = 1'b1;
      end
      pend_nxt = pend_r - 2'd1;
      cp_nxt   = cp_sh;
      // The sequence completes: check the decoded value.
      if (pend_r == SEQ_TWO) begin
        if (bad_cp) begin
          err_nxt = 1'b1;
        end
        cp_nxt  = '0;
        seq_nxt = SEQ_NONE;
      end
    end
  end

  assign status = utf8_status_t'{text_error: err_nxt, seq_open: (pend_nxt != SEQ_NONE)};

  // State advances with each processed byte and clears after the final one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= SEQ_NONE;
      seq_r  <= SEQ_NONE;
      cp_r   <= '0;
      err_r  <= 1'b0;
    end else if (step) begin
      if (flush) begin
        pend_r <= SEQ_NONE;
        seq_r  <= SEQ_NONE;
        cp_r   <= '0;
        err_r  <= 1'b0;
      end else begin
        pend_r <= pend_nxt;
        seq_r  <= seq_nxt;
        cp_r   <= cp_nxt;
        err_r  <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/jeu_key_window.sv */
// Sliding byte window that detects the version key anywhere in a message.
`default_nettype none

module jeu_key_window (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       flush,
  input  wire logic [7:0] data_byte,
  output logic            key_seen
);
  import jeu_pkg::*;

  logic [7:0] win_r [WIN_LEN];
  logic       found_r;
  logic       match;

  // Compare the held bytes plus the new byte with the key text.
  always_comb begin
    match = (data_byte == KEY_TEXT[KEY_LEN-1]);
    for (int i = 0; i < WIN_LEN; i++) begin
      if (win_r[i] != KEY_TEXT[i]) begin
        match = 1'b0;
      end
    end
  end

  assign key_seen = found_r | match;

  // Shift the window, newest byte at the top; clear between messages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (step) begin
      if (flush) begin
        found_r <= 1'b0;
        for (int i = 0; i < WIN_LEN; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        found_r <= key_seen;
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_LEN-1] <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/json_envelope_utf8_checker.sv */
// Top level of the response envelope checker: length, UTF-8, braces and key.
//
//  Channel | Direction | Handshake   | Payload
//  in_chan | sink      | valid/ready | data_byte[7:0], last_byte
//  out_chan| source    | valid/ready | verdict[1:0], message_length[24:0]
//  cfg     | sink      | cfg_wr_en   | cfg_wr_data[23:0] (max_length)
//
// One byte per cycle sustained unless a final byte stalls; each byte is held in
// the input register, and a final byte's verdict goes into the output register.
// Only a final byte produces an item; other bytes never wait on the output side.
// Reset is synchronous and active low; max_length returns to 65536.
// A final byte stalls in the input register while an earlier verdict is not taken.
`default_nettype none

module json_envelope_utf8_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  jeu_in_if.sink                 in_chan,
  jeu_out_if.source              out_chan,
  input  wire logic              cfg_wr_en,
  input  wire logic [23:0]       cfg_wr_data
);
  import jeu_pkg::*;

  logic [MAX_LEN_W-1:0] max_length_r;

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;

  logic [LEN_W-1:0]     byte_count_r, byte_count_nxt;
  logic                 opened_r, opened_nxt;

  logic                 out_valid_r;
  verdict_t             out_verdict_r, verdict_nxt;
  logic [LEN_W-1:0]     out_length_r;

  logic                 advance;
  logic                 flush;
  logic                 key_seen;
  utf8_status_t         utf8_status;

  // A held byte moves on unless it is final and the output is still occupied.
  assign advance = s1_valid_r &&
                   (!s1_last_r || !out_valid_r || out_chan.ready);
  assign flush = s1_last_r;
  assign in_chan.ready = !s1_valid_r || advance;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.verdict        = out_verdict_r;
  assign out_chan.message_length = out_length_r;

  jeu_utf8_tracker u_utf8 (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .flush     (flush),
    .data_byte (s1_byte_r),
    .status    (utf8_status)
  );

  jeu_key_window u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .flush     (flush),
    .data_byte (s1_byte_r),
    .key_seen  (key_seen)
  );

  // Length, brace checks and the verdict for a final byte.
  always_comb begin
    byte_count_nxt = (byte_count_r < COUNT_CAP) ? byte_count_r + 25'd1 : byte_count_r;
    opened_nxt = (byte_count_r == '0) ? (s1_byte_r == OPEN_BRACE) : opened_r;
    if (byte_count_nxt > {1'b0, max_length_r}) begin
      verdict_nxt = VERDICT_TOO_LARGE;
    end else if ((byte_count_nxt < 25'd2) || utf8_status.text_error ||
                 utf8_status.seq_open || !opened_nxt ||
                 (s1_byte_r != CLOSE_BRACE) || !key_seen) begin
      verdict_nxt = VERDICT_MALFORMED;
    end else begin
      verdict_nxt = VERDICT_VALID;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // Per-message counters, cleared after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      opened_r     <= 1'b0;
    end else if (advance) begin
      if (flush) begin
        byte_count_r <= '0;
        opened_r     <= 1'b0;
      end else begin
        byte_count_r <= byte_count_nxt;
        opened_r     <= opened_nxt;
      end
    end
  end

  // Output register holds one verdict item until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && flush) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && flush) begin
      out_verdict_r <= verdict_nxt;
      out_length_r  <= byte_count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The byte counter starts from zero after every final byte.
  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && flush) |=> (byte_count_r == '0))
    else $error("byte count not cleared after final byte");

  // Input stalls only behind a final byte blocked by an untaken verdict.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a blocked verdict");

  // A reported message always holds at least its final byte.
  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_length_r != '0))
    else $error("verdict reported with zero length");

  // A message shorter than two bytes is never valid.
  a_short_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_length_r < 25'd2)) |-> (out_verdict_r != VERDICT_VALID))
    else $error("short message reported valid");
`endif

endmodule

`default_nettype wire
